@@ hw/rtl/five_point_stencil_blur_assert.svh @@
// ---------------------------------------------------------------------------
// Five-point stencil blur assertion macros
// Shared property forms for the checker that watches the block's ports.
// ---------------------------------------------------------------------------
`ifndef FIVE_POINT_STENCIL_BLUR_ASSERT_SVH
`define FIVE_POINT_STENCIL_BLUR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define FPSB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpsb same-cycle property failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define FPSB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpsb next-cycle property failed");

// Checked through reset as well, for properties about reset itself.
`define FPSB_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fpsb reset property failed");

`endif

@@ hw/rtl/fpsb_pkg.sv @@
// ---------------------------------------------------------------------------
// Five-point stencil blur package
// Field widths, register indexes, reset values and the structs passed
// between the front, the queue and the back.
// ---------------------------------------------------------------------------
package fpsb_pkg;

  localparam int PIX_W      = 16;
  localparam int NSUM_W     = 18;
  localparam int WGT_W      = 12;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Job queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Products and rounding.
  localparam int PROD_C_W  = WGT_W + PIX_W;
  localparam int PROD_N_W  = WGT_W + NSUM_W;
  localparam int ACC_W     = 31;
  localparam int FRAC_BITS = 12;
  localparam int ROUND_ADD = 2048;

  // Register reset values.
  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST     = 11'd1024;
  localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST    = 16'd1024;
  localparam logic [WGT_W-1:0] CENTER_WEIGHT_RST   = 12'd1638;
  localparam logic [WGT_W-1:0] NEIGHBOR_WEIGHT_RST = 12'd614;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH     = 2'd0,
    REG_FRAME_HEIGHT    = 2'd1,
    REG_CENTER_WEIGHT   = 2'd2,
    REG_NEIGHBOR_WEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [FW_W-1:0] frame_width;
    logic [FH_W-1:0] frame_height;
  } geom_t;

  typedef struct packed {
    logic [WGT_W-1:0] center_weight;
    logic [WGT_W-1:0] neighbor_weight;
  } wgt_t;

  typedef struct packed {
    logic [PIX_W-1:0]  center;
    logic [NSUM_W-1:0] nsum;
    logic              last;
  } job_t;

endpackage

@@ hw/rtl/fpsb_front.sv @@
// ---------------------------------------------------------------------------
// Five-point stencil blur front
// Tracks the raster position, reads and rewrites the line store, keeps the
// window taps and hands one job per interior pixel to the queue.
// ---------------------------------------------------------------------------
module fpsb_front
  import fpsb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  geom_t             geom,
  input  logic [PIX_W-1:0]  pixel_in,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [QCNT_W-1:0] q_count,
  output logic              job_valid,
  output job_t              job
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WCW   = $clog2(MAX_WIDTH + 1);

  logic [COL_W-1:0]    col;
  logic [FH_W-1:0]     row;
  logic [WCW-1:0]      eff_w;
  logic [FH_W-1:0]     eff_h;
  logic [WCW-1:0]      col_inc;
  logic [FH_W:0]       row_inc;
  logic                row_end;
  logic                frame_end;
  logic                emit;
  logic                accept;

  logic                s1_valid;
  logic [PIX_W-1:0]    s1_pix;
  logic [COL_W-1:0]    s1_addr;
  logic                s1_emit;
  logic                s1_last;

  logic [2*PIX_W-1:0]  line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]  rd_word;
  logic [PIX_W-1:0]    rd_prev;
  logic [PIX_W-1:0]    rd_old;

  logic [PIX_W-1:0]    tap_center;
  logic [PIX_W-1:0]    tap_left;
  logic [PIX_W-1:0]    tap_down;
  logic [PIX_W-1:0]    tap_up;

  // Clamp the frame size registers to the supported range.
  always_comb begin
    if (geom.frame_width < 11'd3) begin
      eff_w = WCW'(3);
    end else if (32'(geom.frame_width) > 32'(MAX_WIDTH)) begin
      eff_w = WCW'(MAX_WIDTH);
    end else begin
      eff_w = WCW'(geom.frame_width);
    end
    eff_h = (geom.frame_height < 16'd3) ? 16'd3 : geom.frame_height;
  end

  // Position flags of the incoming pixel.
  assign col_inc   = WCW'(col) + WCW'(1);
  assign row_inc   = {1'b0, row} + 17'd1;
  assign row_end   = (col_inc >= eff_w);
  assign frame_end = row_end && (row_inc >= {1'b0, eff_h});
  assign emit      = (row >= 16'd2) && (col >= COL_W'(2));

  // Take a pixel only when the queue has room for every job in flight.
  assign in_ready = (({1'b0, q_count} + {{QCNT_W{1'b0}}, s1_valid}) <
                     (QCNT_W + 1)'(QDEPTH));
  assign accept   = in_valid && in_ready;

  // Raster position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (row_end) begin
        col <= '0;
        row <= frame_end ? '0 : row_inc[FH_W-1:0];
      end else begin
        col <= col_inc[COL_W-1:0];
      end
    end
  end

  // Register stage that holds the pixel while the line store read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_pix  <= pixel_in;
      s1_addr <= col;
      s1_emit <= emit;
      s1_last <= frame_end;
    end
  end

  // Line store: upper half holds the previous row, lower half the one before.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word <= line_mem[col];
    end
    if (s1_valid) begin
      line_mem[s1_addr] <= {s1_pix, rd_prev};
    end
  end

  assign rd_prev = rd_word[2*PIX_W-1:PIX_W];
  assign rd_old  = rd_word[PIX_W-1:0];

  // Window taps shift once per pixel that leaves the read stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_center <= '0;
      tap_left   <= '0;
      tap_down   <= '0;
      tap_up     <= '0;
    end else if (s1_valid) begin
      tap_left   <= tap_center;
      tap_center <= rd_prev;
      tap_up     <= rd_old;
      tap_down   <= s1_pix;
    end
  end

  // Job for the back: center pixel and the sum of its four neighbors.
  assign job_valid  = s1_valid && s1_emit;
  assign job.center = tap_center;
  assign job.nsum   = NSUM_W'(tap_up) + NSUM_W'(tap_down) + NSUM_W'(tap_left) +
                      NSUM_W'(rd_prev);
  assign job.last   = s1_last;

endmodule

@@ hw/rtl/fpsb_queue.sv @@
// ---------------------------------------------------------------------------
// Five-point stencil blur job queue
// Short first-in first-out buffer that lets the front and the back stall
// independently.
// ---------------------------------------------------------------------------
module fpsb_queue
  import fpsb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  job_t              push_data,
  input  logic              pop_ready,
  output logic              pop_valid,
  output job_t              pop_data,
  output logic [QCNT_W-1:0] count
);

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              pop;

  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = entries[rd_ptr];

  // Pointers and fill level; the front never pushes into a full queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ hw/rtl/fpsb_back.sv @@
// ---------------------------------------------------------------------------
// Five-point stencil blur back
// Weights the center and the neighbor sum, rounds, saturates and holds the
// result in the output register.
// ---------------------------------------------------------------------------
module fpsb_back
  import fpsb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  wgt_t             wgt,
  input  logic             q_valid,
  input  job_t             q_job,
  output logic             q_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] pixel_out,
  output logic             frame_last
);

  logic                m_valid;
  logic [PROD_C_W-1:0] m_prod_c;
  logic [PROD_N_W-1:0] m_prod_n;
  logic                m_last;
  logic                out_load;
  logic                m_take;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-FRAC_BITS-1:0] scaled;
  logic [PIX_W-1:0]    sat_pix;

  assign out_load = m_valid && (!out_valid || out_ready);
  assign m_take   = q_valid && (!m_valid || out_load);
  assign q_ready  = !m_valid || out_load;

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_take) begin
      m_valid <= 1'b1;
    end else if (out_load) begin
      m_valid <= 1'b0;
    end
    if (m_take) begin
      m_prod_c <= PROD_C_W'(wgt.center_weight) * PROD_C_W'(q_job.center);
      m_prod_n <= PROD_N_W'(wgt.neighbor_weight) * PROD_N_W'(q_job.nsum);
      m_last   <= q_job.last;
    end
  end

  // Add, round half up and clip at the top of the pixel range.
  assign acc     = ACC_W'(m_prod_c) + ACC_W'(m_prod_n) + ACC_W'(ROUND_ADD);
  assign scaled  = acc[ACC_W-1:FRAC_BITS];
  assign sat_pix = (|scaled[ACC_W-FRAC_BITS-1:PIX_W]) ? '1 : scaled[PIX_W-1:0];

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      pixel_out  <= sat_pix;
      frame_last <= m_last;
    end
  end

endmodule

@@ hw/rtl/five_point_stencil_blur.sv @@
// ---------------------------------------------------------------------------
// Five-point stencil blur
// Blurs a raster pixel stream with a center plus four-neighbor stencil and
// gives one result for every interior pixel of the frame.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    pixel_in
//   output    out_valid / out_ready  pixel_out, frame_last
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel is taken every clock while the job queue has room; the line store
// does one read and one write per pixel, which sets that rate. Results pass
// through the read stage, job queue, multiply stage and output register.
// Reset clears the counters, taps and queue; the line store needs no clearing
// pass. An output stall fills the four-entry job queue and in_ready drops.
// Config writes are taken every cycle.
module five_point_stencil_blur
  import fpsb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [PIX_W-1:0]      pixel_in,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic [PIX_W-1:0]      pixel_out,
  output logic                  frame_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  geom_t             geom;
  wgt_t              wgt;
  logic              job_valid;
  job_t              job;
  logic [QCNT_W-1:0] q_count;
  logic              q_valid;
  job_t              q_job;
  logic              q_ready;
  cfg_reg_t          cfg_reg;

  assign cfg_ready = 1'b1;
  assign cfg_reg   = cfg_reg_t'(cfg_index);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      geom.frame_width    <= FRAME_WIDTH_RST;
      geom.frame_height   <= FRAME_HEIGHT_RST;
      wgt.center_weight   <= CENTER_WEIGHT_RST;
      wgt.neighbor_weight <= NEIGHBOR_WEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg)
        REG_FRAME_WIDTH:     geom.frame_width    <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT:    geom.frame_height   <= cfg_data[FH_W-1:0];
        REG_CENTER_WEIGHT:   wgt.center_weight   <= cfg_data[WGT_W-1:0];
        REG_NEIGHBOR_WEIGHT: wgt.neighbor_weight <= cfg_data[WGT_W-1:0];
        default:             geom.frame_width    <= geom.frame_width;
      endcase
    end
  end

  fpsb_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .pixel_in  (pixel_in),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .q_count   (q_count),
    .job_valid (job_valid),
    .job       (job)
  );

  fpsb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid),
    .push_data (job),
    .pop_ready (q_ready),
    .pop_valid (q_valid),
    .pop_data  (q_job),
    .count     (q_count)
  );

  fpsb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .wgt        (wgt),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .q_ready    (q_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

endmodule

@@ hw/rtl/fpsb_checker.sv @@
// ---------------------------------------------------------------------------
// Five-point stencil blur port checker
// Watches the block's ports for reset behavior, output stalls and input
// back-pressure.
// ---------------------------------------------------------------------------
`include "five_point_stencil_blur_assert.svh"

module fpsb_checker
  import fpsb_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic [PIX_W-1:0]      pixel_out,
  input logic                  frame_last,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  cfg_valid,
  input logic                  cfg_ready
);

  // Reset empties the output and opens the input.
  `FPSB_ASSERT_RESET(a_reset_clears, rst, !out_valid && in_ready)

  // A stalled result keeps its value until the transfer.
  `FPSB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(frame_last))

  // Input back-pressure only builds up behind a waiting result.
  `FPSB_ASSERT_SAME(a_stall_cause, !in_ready, out_valid)

  // The configuration port never pushes back.
  `FPSB_ASSERT_SAME(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind five_point_stencil_blur fpsb_checker u_fpsb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .pixel_out  (pixel_out),
  .frame_last (frame_last),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

@@ sim/tb_five_point_stencil_blur.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Five-point stencil blur testbench
// Streams frames of pixels into the blur through its valid/ready input and
// programs frame size and weights between phases. A scoreboard keeps its own
// line stores and window taps, works out every blurred interior pixel, and
// checks each output transfer against the oldest one still owed. Directed
// frames cover saturation, rounding and out-of-range sizes; random frames
// follow with random idling on both sides and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_five_point_stencil_blur;
  import fpsb_pkg::*;

  localparam int MAX_WIDTH    = 1024;
  localparam int SETTLE       = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 570;
  localparam int RANDOM_SLACK = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } blurred_pixel_t;

  // Scoreboard: predicts the blurred pixels from the accepted input stream.
  class blur_scoreboard;
    logic [FW_W-1:0]  frame_width;
    logic [FH_W-1:0]  frame_height;
    logic [WGT_W-1:0] center_weight;
    logic [WGT_W-1:0] neighbor_weight;
    bit [PIX_W-1:0]   prev_row  [MAX_WIDTH];
    bit [PIX_W-1:0]   older_row [MAX_WIDTH];
    bit [PIX_W-1:0]   tap_center, tap_left, tap_down, tap_up;
    int unsigned      col, row;
    blurred_pixel_t   pending_blurs [$];
    int unsigned      failures;

    function new();
      frame_width     = FRAME_WIDTH_RST;
      frame_height    = FRAME_HEIGHT_RST;
      center_weight   = CENTER_WEIGHT_RST;
      neighbor_weight = NEIGHBOR_WEIGHT_RST;
      col = 0;
      row = 0;
      tap_center = '0;
      tap_left   = '0;
      tap_down   = '0;
      tap_up     = '0;
      failures   = 0;
      foreach (prev_row[i]) begin
        prev_row[i]  = '0;
        older_row[i] = '0;
      end
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_FRAME_WIDTH:     frame_width     = value[FW_W-1:0];
        REG_FRAME_HEIGHT:    frame_height    = value[FH_W-1:0];
        REG_CENTER_WEIGHT:   center_weight   = value[WGT_W-1:0];
        REG_NEIGHBOR_WEIGHT: neighbor_weight = value[WGT_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the window by one accepted pixel and queue any blurred result.
    function void note_pixel(logic [PIX_W-1:0] pix);
      int unsigned       w, h, addr;
      bit [PIX_W-1:0]    rd_prev, rd_old;
      bit                row_end, frame_end;
      longint unsigned   nsum, acc, res;
      blurred_pixel_t    blur;
      w = (frame_width < 3) ? 3 : ((frame_width > MAX_WIDTH) ? MAX_WIDTH : frame_width);
      h = (frame_height < 3) ? 3 : frame_height;
      addr = (col < MAX_WIDTH) ? col : 0;
      rd_prev = prev_row[addr];
      rd_old  = older_row[addr];
      row_end   = (col + 1) >= w;
      frame_end = row_end && ((row + 1) >= h);

      // Interior centers complete once two rows and two columns have passed.
      if (row >= 2 && col >= 2) begin
        nsum = longint'(tap_up) + tap_down + tap_left + rd_prev;
        acc  = longint'(center_weight) * tap_center + longint'(neighbor_weight) * nsum;
        res  = (acc + 2048) >> 12;
        if (res > 64'hFFFF) res = 64'hFFFF;
        blur.pixel = res[PIX_W-1:0];
        blur.last  = frame_end;
        pending_blurs.push_back(blur);
      end

      tap_left   = tap_center;
      tap_center = rd_prev;
      tap_up     = rd_old;
      tap_down   = pix;
      older_row[addr] = rd_prev;
      prev_row[addr]  = pix;

      if (row_end) begin
        col = 0;
        row = frame_end ? 0 : ((row + 1) & 32'hFFFF);
      end else begin
        col = col + 1;
      end
    endfunction

    // Compare one output transfer with the oldest owed result.
    function void check_blur(logic [PIX_W-1:0] pix, logic last);
      blurred_pixel_t want;
      if (pending_blurs.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: unexpected result pixel_out=%0d frame_last=%0b", $time, pix, last);
        return;
      end
      want = pending_blurs.pop_front();
      if (pix !== want.pixel || last !== want.last) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: mismatch pixel_out exp %0d got %0d, frame_last exp %0b got %0b",
                   $time, want.pixel, pix, want.last, last);
      end
    endfunction

    function int pending();
      return pending_blurs.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic [PIX_W-1:0]      pixel_in;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel_out;
  logic                  frame_last;
  logic                  out_valid;
  logic                  out_ready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  blur_scoreboard board;
  int unsigned    idle_pct = 26;
  bit             hold_output = 1'b0;
  bit             hold_served = 1'b0;

  five_point_stencil_blur #(
    .MAX_WIDTH(MAX_WIDTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_in),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_out (pixel_out),
    .frame_last(frame_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one pixel after a random idle gap and hold it until the transfer.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= pix;
    do @(posedge clk); while (!in_ready);
    board.note_pixel(pix);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input int unsigned mode);
    case (mode)
      0: return PIX_W'($urandom_range(0, 65535));
      1: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return PIX_W'($urandom_range(0, 65535));
        endcase
      end
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixels(input int unsigned count, input int unsigned mode);
    for (int unsigned i = 0; i < count; i++) send_pixel(pick_pixel(mode));
  endtask

  // Write one register; keep valid high when another write follows.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, value);
    if (!more) cfg_valid <= 1'b0;
  endtask

  // Stop offering pixels and wait for every owed result plus the pipeline tail.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [WGT_W-1:0] pick_weight(input logic [WGT_W-1:0] dflt);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return dflt;
      default: return WGT_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // Output side: check every transfer, toggle ready at random, hold off once.
  initial begin
    out_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) board.check_blur(pixel_out, frame_last);
      if (hold_output && !hold_served) begin
        hold_served = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_five_point_stencil_blur failed");
    $finish;
  end

  // Main stimulus.
  initial begin
    logic [PIX_W-1:0] frame9 [9];
    int unsigned      w, h, frames, mode, random_items, phase, lead;
    board = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    pixel_in  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sizes below range fall back to 3x3; full weights on full-scale pixels saturate.
    write_reg(REG_FRAME_WIDTH, 16'd1, 1'b1);
    write_reg(REG_FRAME_HEIGHT, 16'd0, 1'b1);
    write_reg(REG_CENTER_WEIGHT, 16'hFFFF, 1'b1);
    write_reg(REG_NEIGHBOR_WEIGHT, 16'h0FFF, 1'b0);
    frame9 = '{default: 16'hFFFF};
    foreach (frame9[i]) send_pixel(frame9[i]);
    finish_phase();

    // Center weight one half on a center of one: an exact half rounds up.
    write_reg(REG_FRAME_WIDTH, 16'd2, 1'b1);
    write_reg(REG_FRAME_HEIGHT, 16'd2, 1'b1);
    write_reg(REG_CENTER_WEIGHT, 16'd2048, 1'b1);
    write_reg(REG_NEIGHBOR_WEIGHT, 16'd0, 1'b0);
    frame9 = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0};
    foreach (frame9[i]) send_pixel(frame9[i]);
    finish_phase();

    // Neighbor sum just under one half of an LSB rounds down to zero.
    write_reg(REG_FRAME_WIDTH, 16'd3, 1'b1);
    write_reg(REG_FRAME_HEIGHT, 16'd3, 1'b1);
    write_reg(REG_CENTER_WEIGHT, 16'd0, 1'b1);
    write_reg(REG_NEIGHBOR_WEIGHT, 16'd1, 1'b0);
    frame9 = '{16'd0, 16'd0, 16'd0, 16'd2047, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0};
    foreach (frame9[i]) send_pixel(frame9[i]);
    finish_phase();

    // Tallest frame setting, cut short by lowering the height mid-frame.
    write_reg(REG_FRAME_WIDTH, 16'd5, 1'b1);
    write_reg(REG_FRAME_HEIGHT, 16'hFFFF, 1'b1);
    write_reg(REG_CENTER_WEIGHT, {4'($urandom), pick_weight(CENTER_WEIGHT_RST)}, 1'b1);
    write_reg(REG_NEIGHBOR_WEIGHT, {4'($urandom), pick_weight(NEIGHBOR_WEIGHT_RST)}, 1'b0);
    send_pixels(5 * 10, 0);
    finish_phase();
    write_reg(REG_FRAME_HEIGHT, 16'd3, 1'b0);
    send_pixels(5, 1);
    finish_phase();

    // Random frames; the first one runs with no idling on either side.
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 0) begin
        idle_pct = 0;
        w = $urandom_range(24, 40);
        h = $urandom_range(5, 8);
      end else begin
        idle_pct = 26;
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
        h = $urandom_range(3, 7);
      end
      frames = $urandom_range(1, 2);
      mode   = $urandom_range(0, 2);
      // Shrink the last frame so the run stays near its item budget.
      if (random_items + w * h * frames > RANDOM_ITEMS + RANDOM_SLACK) begin
        frames = 1;
        h = 3;
        w = (RANDOM_ITEMS + RANDOM_SLACK - random_items) / 3;
      end
      write_reg(REG_FRAME_WIDTH, {5'($urandom), 11'(w)}, 1'b1);
      write_reg(REG_FRAME_HEIGHT, 16'(h), 1'b1);
      write_reg(REG_CENTER_WEIGHT, {4'($urandom), pick_weight(CENTER_WEIGHT_RST)}, 1'b1);
      write_reg(REG_NEIGHBOR_WEIGHT, {4'($urandom), pick_weight(NEIGHBOR_WEIGHT_RST)}, 1'b0);
      if (phase == 0) begin
        // Hold the output off once results flow, while pixels keep coming.
        lead = 2 * w + 8;
        send_pixels(lead, mode);
        hold_output = 1'b1;
        send_pixels(w * h * frames - lead, mode);
      end else begin
        send_pixels(w * h * frames, mode);
      end
      finish_phase();
      random_items += w * h * frames;
      phase++;
    end

    if (board.failures == 0 && board.pending() == 0)
      $display("tb_five_point_stencil_blur passed");
    else
      $display("tb_five_point_stencil_blur failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/fpsb_pkg.sv
hw/rtl/fpsb_front.sv
hw/rtl/fpsb_queue.sv
hw/rtl/fpsb_back.sv
hw/rtl/five_point_stencil_blur.sv
hw/rtl/fpsb_checker.sv
sim/tb_five_point_stencil_blur.sv
